// File: rtl/ipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, codes and a checksum helper shared by the IPv4 receive classifier.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int PORT_SLOTS = 5;

    localparam logic [3:0] CFG_LOCAL_ADDR  = 4'd0;
    localparam logic [3:0] CFG_SUBNET_MASK = 4'd1;
    localparam logic [3:0] CFG_FILTER_ON   = 4'd2;
    localparam logic [3:0] CFG_PORT_FIRST  = 4'd3;
    localparam logic [3:0] CFG_PORT_LAST   = 4'd7;

    localparam logic [31:0] LOCAL_ADDR_RST  = 32'hA9FE_0000;
    localparam logic [31:0] SUBNET_MASK_RST = 32'hFFFF_0000;
    localparam logic [15:0] PORT0_RST       = 16'd68;
    localparam logic [15:0] PORT1_RST       = 16'd161;

    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
    localparam logic [7:0] IP_VERSION4   = 8'h40;
    localparam logic [7:0] VERSION_MASK  = 8'hF0;
    localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    typedef enum logic [3:0] {
        V_ECHO        = 4'd0,
        V_UDP         = 4'd1,
        V_NOT_ME      = 4'd2,
        V_VERSION     = 4'd3,
        V_HDR_LEN     = 4'd4,
        V_TOT_LEN     = 4'd5,
        V_IP_CSUM     = 4'd6,
        V_FRAG        = 4'd7,
        V_ICMP_CSUM   = 4'd8,
        V_ICMP_OTHER  = 4'd9,
        V_UDP_LEN     = 4'd10,
        V_UDP_CSUM    = 4'd11,
        V_PORT_ZERO   = 4'd12,
        V_NO_SOCKET   = 4'd13,
        V_OTHER_PROTO = 4'd14
    } t_verdict;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] subnet_mask;
        logic        filter_on;
        logic [PORT_SLOTS-1:0][15:0] ports;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  vih;
        logic [15:0] tot_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [15:0] ip_csum;
        logic [15:0] ip_acc;
        logic [31:0] src;
        logic [31:0] dst;
        logic [63:0] l4_hdr;
        logic [15:0] l4_acc;
        logic [15:0] count;
    } t_rec;

    typedef struct packed {
        t_verdict    verdict;
        logic [2:0]  socket_index;
        logic [31:0] source_addr;
        logic        source_is_local;
        logic [5:0]  header_bytes;
        logic [15:0] payload_length;
        logic [15:0] udp_source_port;
        logic [15:0] udp_target_port;
    } t_res;

    function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = {1'b0, s[15:0]} + {16'd0, s[16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// File: rtl/ipc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_fifo
// Small synchronous queue with registered entries and a visible head.
// ----------------------------------------------------------------------------
module ipc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

// File: rtl/ipc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_front
// Byte parser: captures header fields and keeps running checksums per byte.
// ----------------------------------------------------------------------------
module ipc_front import ipc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_last,
    output logic       o_rec_valid,
    output t_rec       o_rec
);
    logic [15:0] r_cnt, r_tl, r_frag, r_ipcs, r_ipacc, r_l4acc;
    logic [7:0]  r_vih, r_proto;
    logic [31:0] r_src, r_dst;
    logic [63:0] r_h;

    logic [15:0] n_cnt, n_tl, n_frag, n_ipcs, n_ipacc, n_l4acc;
    logic [7:0]  n_vih, n_proto;
    logic [31:0] n_src, n_dst;
    logic [63:0] n_h;

    logic [15:0] n, hl16, o, weighted, l4len, udp_len;
    logic [7:0]  b;
    logic        in_l4, skip;

    always_comb begin
        b      = i_data_byte;
        n      = r_cnt;
        n_vih  = (n == 16'd0) ? b : r_vih;
        n_tl   = r_tl;
        n_frag = r_frag;
        n_ipcs = r_ipcs;
        n_proto = (n == 16'd9) ? b : r_proto;
        n_src  = r_src;
        n_dst  = r_dst;
        case (n)
            16'd2:   n_tl = {b, r_tl[7:0]};
            16'd3:   n_tl = {r_tl[15:8], b};
            16'd6:   n_frag = {b, r_frag[7:0]};
            16'd7:   n_frag = {r_frag[15:8], b};
            16'd10:  n_ipcs = {b, r_ipcs[7:0]};
            16'd11:  n_ipcs = {r_ipcs[15:8], b};
            16'd12, 16'd13, 16'd14, 16'd15: n_src = {r_src[23:0], b};
            16'd16, 16'd17, 16'd18, 16'd19: n_dst = {r_dst[23:0], b};
            default: ;
        endcase

        hl16     = {10'd0, n_vih[3:0], 2'b00};
        weighted = n[0] ? {8'd0, b} : {b, 8'd0};
        n_ipacc  = r_ipacc;
        if (n < hl16 && n != 16'd10 && n != 16'd11) begin
            n_ipacc = csum_add(r_ipacc, weighted);
        end

        in_l4 = (n >= hl16);
        o     = n - hl16;
        n_h   = r_h;
        for (int k = 0; k < 8; k++) begin
            if (in_l4 && o == 16'(k)) begin
                n_h[63-8*k -: 8] = b;
            end
        end

        l4len   = n_tl - hl16;
        udp_len = n_h[31:16];
        skip    = (o == 16'd2 || o == 16'd3) && (o < {l4len[15:1], 1'b0});
        n_l4acc = r_l4acc;
        if (in_l4 && n < n_tl) begin
            if (n_proto == PROTO_ICMP) begin
                if (!skip) begin
                    n_l4acc = csum_add(r_l4acc, weighted);
                end
            end else if (n_proto == PROTO_UDP) begin
                if (o != 16'd6 && o != 16'd7 && (o < 16'd6 || o < udp_len)) begin
                    n_l4acc = csum_add(r_l4acc, weighted);
                end
            end
        end

        n_cnt = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;

        o_rec.vih     = n_vih;
        o_rec.tot_len = n_tl;
        o_rec.frag    = n_frag;
        o_rec.proto   = n_proto;
        o_rec.ip_csum = n_ipcs;
        o_rec.ip_acc  = n_ipacc;
        o_rec.src     = n_src;
        o_rec.dst     = n_dst;
        o_rec.l4_hdr  = n_h;
        o_rec.l4_acc  = n_l4acc;
        o_rec.count   = n_cnt;
    end

    assign o_rec_valid = i_valid && i_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_frame_last)) begin
            r_cnt   <= '0;
            r_vih   <= '0;
            r_tl    <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_ipcs  <= '0;
            r_ipacc <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_h     <= '0;
            r_l4acc <= '0;
        end else if (i_valid) begin
            r_cnt   <= n_cnt;
            r_vih   <= n_vih;
            r_tl    <= n_tl;
            r_frag  <= n_frag;
            r_proto <= n_proto;
            r_ipcs  <= n_ipcs;
            r_ipacc <= n_ipacc;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_h     <= n_h;
            r_l4acc <= n_l4acc;
        end
    end

endmodule

// File: rtl/ipc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_back
// Verdict stage: pseudo-header sum, header checks, port lookup, result queue.
// ----------------------------------------------------------------------------
module ipc_back import ipc_pkg::*; #(
    parameter int SOCKET_COUNT = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_rec_avail,
    input  t_rec i_rec,
    output logic o_rec_take,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);
    t_rec        r_rec;
    logic [15:0] r_pseudo;
    logic        r_s1_v;

    logic [19:0] psum;
    logic [16:0] pf1;
    logic [15:0] pfold;
    logic        s1_adv, res_full;
    t_res        res;
    logic [5:0]  hl;
    logic [15:0] l4len, sport, dport, ulen, ucsum, cs;
    logic        ip_ok, found;
    logic [2:0]  sock;

    always_comb begin
        psum = {4'd0, i_rec.l4_acc} + {4'd0, i_rec.src[31:16]} + {4'd0, i_rec.src[15:0]}
             + {4'd0, i_rec.dst[31:16]} + {4'd0, i_rec.dst[15:0]}
             + {12'd0, PROTO_UDP} + {4'd0, i_rec.l4_hdr[31:16]};
        pf1   = {1'b0, psum[15:0]} + {13'd0, psum[19:16]};
        pfold = pf1[15:0] + {15'd0, pf1[16]};
    end

    assign s1_adv     = r_s1_v && !res_full;
    assign o_rec_take = i_rec_avail && (!r_s1_v || s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_rec_take) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            r_rec    <= i_rec;
            r_pseudo <= pfold;
        end
    end

    always_comb begin
        hl    = {r_rec.vih[3:0], 2'b00};
        l4len = r_rec.tot_len - {10'd0, hl};
        sport = r_rec.l4_hdr[63:48];
        dport = r_rec.l4_hdr[47:32];
        ulen  = r_rec.l4_hdr[31:16];
        ucsum = r_rec.l4_hdr[15:0];
        cs    = ~r_pseudo;
        if (cs == 16'd0) begin
            cs = 16'hFFFF;
        end
        found = 1'b0;
        sock  = 3'd0;
        for (int i = SOCKET_COUNT - 1; i >= 0; i--) begin
            if (i_cfg.ports[i] == dport) begin
                found = 1'b1;
                sock  = 3'(i);
            end
        end

        ip_ok = 1'b0;
        res.socket_index    = 3'd0;
        res.payload_length  = '0;
        res.udp_source_port = '0;
        res.udp_target_port = '0;
        if (i_cfg.filter_on && r_rec.dst != i_cfg.local_addr) begin
            res.verdict = V_NOT_ME;
        end else if ((r_rec.vih & VERSION_MASK) != IP_VERSION4) begin
            res.verdict = V_VERSION;
        end else if (hl < MIN_HDR_BYTES) begin
            res.verdict = V_HDR_LEN;
        end else if (r_rec.tot_len < {10'd0, hl} || r_rec.tot_len > r_rec.count) begin
            res.verdict = V_TOT_LEN;
        end else if (~r_rec.ip_acc != r_rec.ip_csum) begin
            res.verdict = V_IP_CSUM;
        end else if (r_rec.frag[13:8] != 6'd0 || r_rec.frag[7:0] != 8'd0) begin
            res.verdict = V_FRAG;
        end else begin
            ip_ok = 1'b1;
            if (r_rec.proto == PROTO_ICMP) begin
                res.payload_length = l4len;
                if (~r_rec.l4_acc != dport) begin
                    res.verdict = V_ICMP_CSUM;
                end else if (sport[15:8] == ICMP_ECHO_REQ) begin
                    res.verdict = V_ECHO;
                end else begin
                    res.verdict = V_ICMP_OTHER;
                end
            end else if (r_rec.proto == PROTO_UDP) begin
                res.udp_source_port = sport;
                res.udp_target_port = dport;
                if (ulen > l4len || ulen < UDP_HDR_BYTES) begin
                    res.verdict = V_UDP_LEN;
                end else begin
                    res.payload_length = ulen - UDP_HDR_BYTES;
                    if (ucsum != 16'd0 && cs != ucsum) begin
                        res.verdict = V_UDP_CSUM;
                    end else if (dport == 16'd0) begin
                        res.verdict = V_PORT_ZERO;
                    end else if (found) begin
                        res.verdict      = V_UDP;
                        res.socket_index = sock;
                    end else begin
                        res.verdict = V_NO_SOCKET;
                    end
                end
            end else begin
                res.verdict = V_OTHER_PROTO;
            end
        end
        res.source_addr     = r_rec.src;
        res.header_bytes    = hl;
        res.source_is_local = ip_ok &&
            ((r_rec.src & i_cfg.subnet_mask) == (i_cfg.local_addr & i_cfg.subnet_mask));
    end

    ipc_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s1_adv),
        .i_data  (res),
        .i_rd    (i_pop),
        .o_data  (o_res),
        .o_full  (res_full),
        .o_empty (o_empty)
    );

endmodule

// File: rtl/ipv4_rx_packet_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_rx_packet_classifier_unit
// IPv4 receive classifier: one byte per transaction, one verdict per packet.
// Throughput: one byte per cycle while full is low, set by the per-byte
// checksum accumulators. Path: the last byte's record passes a two-entry
// queue to the verdict stage, then the stage register and the result queue.
// Reset: synchronous, active low; clears parser state and queues, loads the
// register defaults.
// ----------------------------------------------------------------------------
module ipv4_rx_packet_classifier_unit import ipc_pkg::*; #(
    parameter int SOCKET_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_last,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_verdict,
    output logic [2:0]  o_socket_index,
    output logic [31:0] o_source_addr,
    output logic        o_source_is_local,
    output logic [5:0]  o_header_bytes,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_udp_source_port,
    output logic [15:0] o_udp_target_port,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cfg r_cfg;
    logic rec_valid, rec_take, q_empty, accept;
    t_rec rec_in, rec_out;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_addr  <= LOCAL_ADDR_RST;
            r_cfg.subnet_mask <= SUBNET_MASK_RST;
            r_cfg.filter_on   <= 1'b0;
            r_cfg.ports       <= {16'd0, 16'd0, 16'd0, PORT1_RST, PORT0_RST};
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LOCAL_ADDR) begin
                r_cfg.local_addr <= i_cfg_data;
            end else if (i_cfg_index == CFG_SUBNET_MASK) begin
                r_cfg.subnet_mask <= i_cfg_data;
            end else if (i_cfg_index == CFG_FILTER_ON) begin
                r_cfg.filter_on <= i_cfg_data[0];
            end else if (i_cfg_index >= CFG_PORT_FIRST && i_cfg_index <= CFG_PORT_LAST) begin
                r_cfg.ports[3'(i_cfg_index - CFG_PORT_FIRST)] <= i_cfg_data[15:0];
            end
        end
    end

    assign accept = push && !full;

    ipc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .o_rec_valid  (rec_valid),
        .o_rec        (rec_in)
    );

    ipc_fifo #(
        .W     ($bits(t_rec)),
        .DEPTH (2)
    ) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_valid),
        .i_data  (rec_in),
        .i_rd    (rec_take),
        .o_data  (rec_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    ipc_back #(
        .SOCKET_COUNT (SOCKET_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec_avail (!q_empty),
        .i_rec       (rec_out),
        .o_rec_take  (rec_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_verdict         = res.verdict;
    assign o_socket_index    = res.socket_index;
    assign o_source_addr     = res.source_addr;
    assign o_source_is_local = res.source_is_local;
    assign o_header_bytes    = res.header_bytes;
    assign o_payload_length  = res.payload_length;
    assign o_udp_source_port = res.udp_source_port;
    assign o_udp_target_port = res.udp_target_port;

endmodule

// File: rtl/ipc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks on the classifier's result queue.
// ----------------------------------------------------------------------------
module ipc_checker import ipc_pkg::*; #(
    parameter int SOCKET_COUNT = 5
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_verdict,
    input logic [2:0]  o_socket_index,
    input logic        o_source_is_local,
    input logic [5:0]  o_header_bytes
);
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_verdict))
        else $error("waiting result changed");

    a_socket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_verdict == V_UDP |-> o_socket_index < 3'(SOCKET_COUNT))
        else $error("socket index out of range");

    a_local_needs_ip_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_source_is_local |->
            (o_verdict == V_ECHO || o_verdict == V_UDP || o_verdict >= V_ICMP_CSUM))
        else $error("local flag on failed header");

    a_delivered_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_verdict == V_UDP |-> o_header_bytes >= MIN_HDR_BYTES)
        else $error("delivered packet with short header");

endmodule

bind ipv4_rx_packet_classifier_unit ipc_checker #(
    .SOCKET_COUNT (SOCKET_COUNT)
) u_ipc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .pop               (pop),
    .o_verdict         (o_verdict),
    .o_socket_index    (o_socket_index),
    .o_source_is_local (o_source_is_local),
    .o_header_bytes    (o_header_bytes)
);
